[src/roman_pkg.sv]
`timescale 1ns / 1ps
// roman numeral encoder package: widths, microcode word, control store and letter tables
// no dependencies; used by the interfaces and integer_to_roman_encoder

package roman_pkg;

    localparam int VALUE_W    = 12;
    localparam int SYM_W      = 7;
    localparam int DIG_W      = 4;
    localparam int PLACE_W    = 2;
    localparam int NUM_PLACES = 4;
    localparam int UPC_W      = 4;
    localparam int WEIGHT_W   = 14;
    localparam int MAX_DIGIT  = 9;

    localparam logic [PLACE_W-1:0] PLACE_UNITS     = 2'd0;
    localparam logic [PLACE_W-1:0] PLACE_TENS      = 2'd1;
    localparam logic [PLACE_W-1:0] PLACE_HUNDREDS  = 2'd2;
    localparam logic [PLACE_W-1:0] PLACE_THOUSANDS = 2'd3;

    localparam logic [SYM_W-1:0] ASC_C = 7'h43;
    localparam logic [SYM_W-1:0] ASC_D = 7'h44;
    localparam logic [SYM_W-1:0] ASC_I = 7'h49;
    localparam logic [SYM_W-1:0] ASC_L = 7'h4C;
    localparam logic [SYM_W-1:0] ASC_M = 7'h4D;
    localparam logic [SYM_W-1:0] ASC_V = 7'h56;
    localparam logic [SYM_W-1:0] ASC_X = 7'h58;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    typedef enum logic [1:0] {
        OP_EMIT,
        OP_SPLIT,
        OP_DISPATCH
    } t_op;

    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } t_sel;

    typedef struct packed {
        t_op              op;
        t_sel             sel;
        logic             digit_end;
        logic [UPC_W-1:0] next;
    } t_uword;

    // control store entry points
    localparam logic [UPC_W-1:0] UA_ONE4     = 4'd0;
    localparam logic [UPC_W-1:0] UA_ONE3     = 4'd1;
    localparam logic [UPC_W-1:0] UA_ONE2     = 4'd2;
    localparam logic [UPC_W-1:0] UA_ONE1     = 4'd3;
    localparam logic [UPC_W-1:0] UA_FIVE3    = 4'd4;
    localparam logic [UPC_W-1:0] UA_FIVE2    = 4'd5;
    localparam logic [UPC_W-1:0] UA_FIVE1    = 4'd6;
    localparam logic [UPC_W-1:0] UA_FIVE0    = 4'd7;
    localparam logic [UPC_W-1:0] UA_ONE_FIVE = 4'd8;
    localparam logic [UPC_W-1:0] UA_ONE_TEN  = 4'd9;
    localparam logic [UPC_W-1:0] UA_TEN      = 4'd10;
    localparam logic [UPC_W-1:0] UA_SPLIT    = 4'd11;
    localparam logic [UPC_W-1:0] UA_DISPATCH = 4'd12;

    function automatic t_uword ucode(input logic [UPC_W-1:0] addr);
        t_uword w;
        w = '{op: OP_DISPATCH, sel: SEL_ONE, digit_end: 1'b0, next: UA_DISPATCH};
        unique case (addr)
            UA_ONE4:     w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b0, next: UA_ONE3};
            UA_ONE3:     w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b0, next: UA_ONE2};
            UA_ONE2:     w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b0, next: UA_ONE1};
            UA_ONE1:     w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b1, next: UA_ONE1};
            UA_FIVE3:    w = '{op: OP_EMIT, sel: SEL_FIVE, digit_end: 1'b0, next: UA_ONE3};
            UA_FIVE2:    w = '{op: OP_EMIT, sel: SEL_FIVE, digit_end: 1'b0, next: UA_ONE2};
            UA_FIVE1:    w = '{op: OP_EMIT, sel: SEL_FIVE, digit_end: 1'b0, next: UA_ONE1};
            UA_FIVE0:    w = '{op: OP_EMIT, sel: SEL_FIVE, digit_end: 1'b1, next: UA_FIVE0};
            UA_ONE_FIVE: w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b0, next: UA_FIVE0};
            UA_ONE_TEN:  w = '{op: OP_EMIT, sel: SEL_ONE,  digit_end: 1'b0, next: UA_TEN};
            UA_TEN:      w = '{op: OP_EMIT, sel: SEL_TEN,  digit_end: 1'b1, next: UA_TEN};
            UA_SPLIT:    w = '{op: OP_SPLIT, sel: SEL_ONE, digit_end: 1'b0, next: UA_DISPATCH};
            default:     w = '{op: OP_DISPATCH, sel: SEL_ONE, digit_end: 1'b0,
                               next: UA_DISPATCH};
        endcase
        return w;
    endfunction

    // first control word of a nonzero digit
    function automatic logic [UPC_W-1:0] entry(input logic [DIG_W-1:0] digit,
                                               input logic             thousands);
        logic [UPC_W-1:0] a;
        a = UA_ONE1;
        unique case (digit)
            4'd1:    a = UA_ONE1;
            4'd2:    a = UA_ONE2;
            4'd3:    a = UA_ONE3;
            4'd4:    a = thousands ? UA_ONE4 : UA_ONE_FIVE;
            4'd5:    a = UA_FIVE0;
            4'd6:    a = UA_FIVE1;
            4'd7:    a = UA_FIVE2;
            4'd8:    a = UA_FIVE3;
            4'd9:    a = UA_ONE_TEN;
            default: a = UA_ONE1;
        endcase
        return a;
    endfunction

    function automatic logic [SYM_W-1:0] letter(input logic [PLACE_W-1:0] place,
                                                input t_sel               sel);
        logic [SYM_W-1:0] s;
        s = ASC_M;
        unique case (place)
            PLACE_UNITS:    s = (sel == SEL_ONE) ? ASC_I : (sel == SEL_FIVE) ? ASC_V : ASC_X;
            PLACE_TENS:     s = (sel == SEL_ONE) ? ASC_X : (sel == SEL_FIVE) ? ASC_L : ASC_C;
            PLACE_HUNDREDS: s = (sel == SEL_ONE) ? ASC_C : (sel == SEL_FIVE) ? ASC_D : ASC_M;
            default:        s = ASC_M;
        endcase
        return s;
    endfunction

    // digit times the place weight
    function automatic logic [WEIGHT_W-1:0] weight(input logic [PLACE_W-1:0] place,
                                                   input logic [DIG_W-1:0]   digit);
        logic [WEIGHT_W-1:0] w;
        w = '0;
        unique case (place)
            PLACE_UNITS:    w = WEIGHT_W'(digit);
            PLACE_TENS:     w = WEIGHT_W'(digit * 10);
            PLACE_HUNDREDS: w = WEIGHT_W'(digit * 100);
            default:        w = WEIGHT_W'(digit * 1000);
        endcase
        return w;
    endfunction

    // highest set position of a digit mask
    function automatic logic [PLACE_W-1:0] highest(input logic [NUM_PLACES-1:0] mask);
        logic [PLACE_W-1:0] p;
        p = '0;
        for (int i = 0; i < NUM_PLACES; i++) begin
            if (mask[i]) begin
                p = PLACE_W'(i);
            end
        end
        return p;
    endfunction

endpackage

[src/roman_in_if.sv]
`timescale 1ns / 1ps
// input channel of the roman numeral encoder: valid, ready and one integer word
// depends on roman_pkg

interface roman_in_if;
    import roman_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

[src/roman_out_if.sv]
`timescale 1ns / 1ps
// output channel of the roman numeral encoder: valid, ready, one letter and a last flag
// depends on roman_pkg

interface roman_out_if;
    import roman_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

[src/integer_to_roman_encoder.sv]
`timescale 1ns / 1ps
// roman numeral encoder top level: microcoded sequencer with digit split datapath
// depends on roman_pkg, roman_in_if and roman_out_if
//
// usage
//   i_item carries one integer word (0 to 3999) per handshake. o_sym returns the
//   roman numeral as ascii letters, one word per letter, thousands first, with
//   last set on the final letter. a zero value returns no words at all.
//   the control store runs: three split steps (thousands, hundreds, tens; the
//   units fall out of the last one), one dispatch step, then one emit step per
//   letter, an item having 0 to 15 letters. the first letter is registered on
//   the output by the first emit step, after the split and dispatch steps. the
//   sequencer is shared by all steps, so one item is in work at a time and
//   i_item.ready is high only when idle. the output register lets the last
//   letter wait while a new word is taken. when o_sym.ready is low and a letter
//   is waiting on the output, an emit step holds and the letter stays on the
//   output. reset (synchronous, active low) returns to idle and drops
//   o_sym.valid.

module integer_to_roman_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    roman_in_if.sink    i_item,
    roman_out_if.source o_sym
);
    import roman_pkg::*;

    t_state             r_state, n_state;
    logic [UPC_W-1:0]   r_upc, n_upc;
    logic [VALUE_W-1:0] r_rem, n_rem;
    logic [PLACE_W-1:0] r_place, n_place;
    logic [DIG_W-1:0]   r_dig [NUM_PLACES];
    logic [DIG_W-1:0]   n_dig [NUM_PLACES];
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_symbol, n_symbol;
    logic               r_last, n_last;

    t_uword              uw;
    logic [DIG_W-1:0]    split_dig;
    logic [VALUE_W-1:0]  split_rem;
    logic [NUM_PLACES-1:0] nz;
    logic [NUM_PLACES-1:0] below;
    logic [PLACE_W-1:0]  top_place;
    logic [PLACE_W-1:0]  below_place;
    logic                slot_free;

    assign uw        = ucode(r_upc);
    assign slot_free = !r_out_valid || o_sym.ready;

    assign i_item.ready = (r_state == ST_IDLE);
    assign o_sym.valid  = r_out_valid;
    assign o_sym.symbol = r_symbol;
    assign o_sym.last   = r_last;

    // digit of the current place by comparing against its multiples
    always_comb begin
        split_dig = '0;
        for (int d = 1; d <= MAX_DIGIT; d++) begin
            if ({2'b00, r_rem} >= weight(r_place, DIG_W'(d))) begin
                split_dig = DIG_W'(d);
            end
        end
        split_rem = VALUE_W'({2'b00, r_rem} - weight(r_place, split_dig));
    end

    always_comb begin
        for (int i = 0; i < NUM_PLACES; i++) begin
            nz[i]    = (r_dig[i] != '0);
            below[i] = nz[i] && (PLACE_W'(i) < r_place);
        end
        top_place   = highest(nz);
        below_place = highest(below);
    end

    always_comb begin
        n_state     = r_state;
        n_upc       = r_upc;
        n_rem       = r_rem;
        n_place     = r_place;
        n_dig       = r_dig;
        n_out_valid = r_out_valid && !o_sym.ready;
        n_symbol    = r_symbol;
        n_last      = r_last;

        unique case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_state = ST_BUSY;
                    n_rem   = i_item.value;
                    n_place = PLACE_THOUSANDS;
                    n_upc   = UA_SPLIT;
                end
            end
            ST_BUSY: begin
                unique case (uw.op)
                    OP_SPLIT: begin
                        n_dig[r_place] = split_dig;
                        n_rem          = split_rem;
                        n_place        = r_place - 1'b1;
                        if (r_place == PLACE_TENS) begin
                            n_dig[PLACE_UNITS] = split_rem[DIG_W-1:0];
                            n_upc              = uw.next;
                        end
                    end
                    OP_EMIT: begin
                        if (slot_free) begin
                            n_out_valid = 1'b1;
                            n_symbol    = letter(r_place, uw.sel);
                            n_last      = uw.digit_end && (below == '0);
                            if (uw.digit_end) begin
                                if (below != '0) begin
                                    n_place = below_place;
                                    n_upc   = entry(r_dig[below_place], 1'b0);
                                end else begin
                                    n_state = ST_IDLE;
                                end
                            end else begin
                                n_upc = uw.next;
                            end
                        end
                    end
                    default: begin
                        if (nz == '0) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_place = top_place;
                            n_upc   = entry(r_dig[top_place], top_place == PLACE_THOUSANDS);
                        end
                    end
                endcase
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_upc    <= n_upc;
        r_rem    <= n_rem;
        r_place  <= n_place;
        r_dig    <= n_dig;
        r_symbol <= n_symbol;
        r_last   <= n_last;
    end

endmodule

[dv/integer_to_roman_encoder_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for integer_to_roman_encoder: drives integer words, predicts the letters
// depends on roman_pkg, roman_in_if, roman_out_if and the encoder top level

module integer_to_roman_encoder_tb;
    import roman_pkg::*;

    typedef struct {
        logic [SYM_W-1:0] symbol;
        logic             last;
    } t_letter;

    logic i_clk;
    logic i_rst_n;

    roman_in_if  in_ch ();
    roman_out_if out_ch ();

    integer_to_roman_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (in_ch),
        .o_sym   (out_ch)
    );

    t_letter letters_due[$];
    int      mismatches = 0;
    bit      send_gaps  = 1'b0;
    bit      recv_stalls = 1'b0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #10ms;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // one decimal digit from its unit, five and ten letters
    function automatic void add_digit(ref logic [SYM_W-1:0] seq[$], input int digit,
                                      input logic [SYM_W-1:0] one,
                                      input logic [SYM_W-1:0] five,
                                      input logic [SYM_W-1:0] ten);
        int d;
        d = digit;
        if (d == 9) begin
            seq.push_back(one);
            seq.push_back(ten);
        end else if (d == 4) begin
            seq.push_back(one);
            seq.push_back(five);
        end else begin
            if (d >= 5) begin
                seq.push_back(five);
                d -= 5;
            end
            repeat (d) seq.push_back(one);
        end
    endfunction

    function automatic void predict_numeral(input logic [VALUE_W-1:0] v);
        logic [SYM_W-1:0] seq[$];
        int n;
        n = int'(v);
        repeat (n / 1000) seq.push_back(ASC_M);
        add_digit(seq, (n / 100) % 10, ASC_C, ASC_D, ASC_M);
        add_digit(seq, (n / 10) % 10, ASC_X, ASC_L, ASC_C);
        add_digit(seq, n % 10, ASC_I, ASC_V, ASC_X);
        if (seq.size() > 15) seq = seq[0:14];
        foreach (seq[i]) begin
            letters_due.push_back('{symbol: seq[i], last: (i == seq.size() - 1)});
        end
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // input word: optional gap, then hold valid until taken
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = send_gaps ? pick_idle() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_numeral(v);
        @(negedge i_clk);
    endtask

    // output side backpressure
    initial begin
        int stall_left;
        int len;
        stall_left = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (recv_stalls && $urandom_range(0, 99) < 30) begin
                len = pick_idle();
                if (len == 0) len = 1;
                stall_left = len - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_letter exp_l;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (letters_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected letter %0h last %0b",
                                        out_ch.symbol, out_ch.last));
            end else begin
                exp_l = letters_due.pop_front();
                if (out_ch.symbol !== exp_l.symbol) begin
                    flag_mismatch($sformatf("symbol %0h, expected %0h",
                                            out_ch.symbol, exp_l.symbol));
                end
                if (out_ch.last !== exp_l.last) begin
                    flag_mismatch($sformatf("last %0b, expected %0b on symbol %0h",
                                            out_ch.last, exp_l.last, exp_l.symbol));
                end
            end
        end
    end

    // extremes, every units digit, 4, 5, 8 and 9 in tens and hundreds, zero and every input bit
    task automatic test_directed();
        int vals[] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 40, 90, 400, 900, 1000,
                       3999, 3888, 2048, 96, 1444, 2949, 0, 3000, 555};
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        foreach (vals[i]) send_value(VALUE_W'(vals[i]));
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return VALUE_W'($urandom_range(0, 3999));
        if (r < 70) return VALUE_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                                    + $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
        if (r < 85) return VALUE_W'($urandom_range(0, 30));
        // long numerals built from 3, 4, 8 and 9 digits
        return VALUE_W'($urandom_range(0, 3) * 1000 + (($urandom_range(0, 1)) ? 800 : 900)
                        + (($urandom_range(0, 1)) ? 80 : 40)
                        + (($urandom_range(0, 1)) ? 8 : 9));
    endfunction

    task automatic test_random_streaming(input int count);
        send_gaps   = 1'b0;
        recv_stalls = 1'b0;
        repeat (count) send_value(random_value());
    endtask

    task automatic test_random_backpressure(input int count);
        send_gaps   = 1'b1;
        recv_stalls = 1'b1;
        repeat (count) send_value(random_value());
    endtask

    task automatic test_random_mixed(input int count);
        repeat (count) begin
            send_gaps   = 1'($urandom_range(0, 1));
            recv_stalls = 1'($urandom_range(0, 1));
            send_value(random_value());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random_streaming(90);
        test_random_backpressure(180);
        test_random_mixed(115);

        in_ch.valid <= 1'b0;
        while (letters_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

[sim.f]
src/roman_pkg.sv
src/roman_in_if.sv
src/roman_out_if.sv
src/integer_to_roman_encoder.sv
dv/integer_to_roman_encoder_tb.sv
